>>> hw/rtl/amfc_pkg.sv
// Package: shared constants, types and helpers for the message channel block.
package amfc_pkg;

  localparam int unsigned DefChannels  = 8;
  localparam int unsigned DefRingDepth = 16;
  localparam int unsigned DefMsgBytes  = 8;
  localparam int unsigned DefNameChars = 8;
  localparam int unsigned DefPrincipals = 16;
  localparam int unsigned DefCores     = 4;

  localparam logic [4:0] PeerAny   = 5'd31;
  localparam logic [1:0] RightSend = 2'd1;
  localparam logic [1:0] RightRecv = 2'd2;
  localparam logic [1:0] RightsAll = 2'd3;
  localparam logic [7:0] CharLow   = 8'h20;
  localparam logic [7:0] CharHigh  = 8'h7E;

  typedef enum logic [1:0] {
    CmdCreate = 2'd0,
    CmdOpen   = 2'd1,
    CmdSend   = 2'd2,
    CmdRecv   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StOk      = 4'd0,
    StInval   = 4'd1,
    StNoent   = 4'd2,
    StExists  = 4'd3,
    StNospc   = 4'd4,
    StUnsup   = 4'd5,
    StAccess  = 4'd6,
    StToolong = 4'd7,
    StFull    = 4'd8,
    StEmpty   = 4'd9
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  core;
    logic [3:0]  principal;
    logic [63:0] channel_name;
    logic [4:0]  peer_id;
    logic [3:0]  rights;
    logic [1:0]  peer_rights;
    logic [7:0]  queue_depth;
    logic [7:0]  message_limit;
    logic [3:0]  channel;
    logic [7:0]  length;
    logic [63:0] payload;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  channel_number;
    logic [3:0]  message_length;
    logic [63:0] message_data;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/amfc_ram.sv
// Generic single-port RAM with registered read.
module amfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/amfc_ctrl.sv
// Controller: sequences one request through load, ring read, execute and response.
module amfc_ctrl import amfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ctl_cmd_t cmd_o
);
  typedef enum logic [1:0] {SIdle, SRead, SExec, SResp} state_e;
  state_e state_q, state_d;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SResp);
  assign cmd_o.load  = (state_q == SIdle) && in_valid_i;
  assign cmd_o.exec  = (state_q == SExec);

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (in_valid_i) state_d = SRead;
      SRead:   state_d = SExec;
      SExec:   state_d = SResp;
      SResp:   if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> hw/rtl/amfc_dpath.sv
// Datapath: channel table, name checks, rights checks and message ring memories.
module amfc_dpath import amfc_pkg::*; #(
  parameter int unsigned Channels   = DefChannels,
  parameter int unsigned RingDepth  = DefRingDepth,
  parameter int unsigned MsgBytes   = DefMsgBytes,
  parameter int unsigned NameChars  = DefNameChars,
  parameter int unsigned Principals = DefPrincipals,
  parameter int unsigned Cores      = DefCores
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_cmd_t   cmd_i,
  input  req_t       req_i,
  input  logic [3:0] root_i,
  output rsp_t       rsp_o
);
  localparam int unsigned ChW   = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned SlotW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned CntW  = $clog2(RingDepth + 1);
  localparam int unsigned MemD  = Channels * RingDepth;
  localparam int unsigned AddrW = (MemD > 1) ? $clog2(MemD) : 1;
  localparam int unsigned CoreW = (Cores > 1) ? $clog2(Cores) : 1;

  req_t r_q;

  logic [Channels-1:0]  used_q;
  logic [CoreW-1:0]     core_q   [Channels];
  logic [3:0]           owner_q  [Channels];
  logic [4:0]           peer_q   [Channels];
  logic [1:0]           orights_q[Channels];
  logic [1:0]           prights_q[Channels];
  logic [CntW-1:0]      depth_q  [Channels];
  logic [3:0]           limit_q  [Channels];
  logic [SlotW-1:0]     head_q   [Channels];
  logic [CntW-1:0]      count_q  [Channels];
  logic [63:0]          name_q   [Channels];

  // name form
  logic        name_ok;
  logic [63:0] canon;
  always_comb begin
    logic done, bad;
    logic [7:0] c;
    logic [3:0] n;
    done = 1'b0; bad = 1'b0; n = '0; canon = '0;
    for (int i = 0; i < NameChars; i++) begin
      c = r_q.channel_name[i*8 +: 8];
      if (!done) begin
        if (c == 8'h00) done = 1'b1;
        else if (c < CharLow || c > CharHigh) bad = 1'b1;
        else begin
          canon[i*8 +: 8] = c;
          n = n + 4'd1;
        end
      end
    end
    if (!done && NameChars < 8) begin
      if (r_q.channel_name[(NameChars%8)*8 +: 8] != 8'h00) bad = 1'b1;
    end
    name_ok = !bad && (n != 4'd0);
  end

  logic          found;
  logic [ChW-1:0] found_idx;
  logic          free_any;
  logic [ChW-1:0] free_idx;
  always_comb begin
    found = 1'b0; found_idx = '0; free_any = 1'b0; free_idx = '0;
    for (int i = Channels - 1; i >= 0; i--) begin
      if (used_q[i] && name_q[i] == canon) begin
        found = 1'b1; found_idx = ChW'(i);
      end
      if (!used_q[i]) begin
        free_any = 1'b1; free_idx = ChW'(i);
      end
    end
  end

  logic           chan_ok;
  logic [ChW-1:0] sel;
  assign chan_ok = ({1'b0, r_q.channel} < 5'(Channels));
  always_comb begin
    if (r_q.command == CmdOpen) sel = found_idx;
    else sel = r_q.channel[ChW-1:0];
  end

  logic [1:0] rts;
  always_comb begin
    if (r_q.principal == root_i) rts = RightsAll;
    else if (r_q.principal == owner_q[sel]) rts = orights_q[sel];
    else if (peer_q[sel] == PeerAny || {1'b0, r_q.principal} == peer_q[sel])
      rts = prights_q[sel];
    else rts = 2'b00;
  end

  // ring slot address
  logic [SlotW-1:0] slot;
  always_comb begin
    logic [CntW:0] s;
    s = (CntW+1)'(head_q[sel]) + (CntW+1)'(count_q[sel]);
    if (s >= (CntW+1)'(depth_q[sel])) s = s - (CntW+1)'(depth_q[sel]);
    if (r_q.command == CmdSend) slot = SlotW'(s);
    else slot = head_q[sel];
  end

  logic [AddrW-1:0] addr;
  assign addr = AddrW'(sel) * AddrW'(RingDepth) + AddrW'(slot);

  logic        core_match;
  logic        wr_en;
  logic [3:0]  rd_len;
  logic [63:0] rd_data;
  logic [63:0] wr_data;
  assign core_match = (CoreW'(r_q.core) == core_q[sel]) && ({2'b0, r_q.core} < 4'(Cores));
  assign wr_data = r_q.payload & byte_mask(r_q.length[3:0]);

  amfc_ram #(.Width(4), .Depth(MemD)) u_len_ram (
    .clk_i, .we_i(wr_en), .addr_i(addr), .wdata_i(r_q.length[3:0]), .rdata_o(rd_len)
  );
  amfc_ram #(.Width(64), .Depth(MemD)) u_frame_ram (
    .clk_i, .we_i(wr_en), .addr_i(addr), .wdata_i(wr_data), .rdata_o(rd_data)
  );

  status_e   st;
  logic      do_create, do_send, do_recv;
  always_comb begin
    st = StOk; do_create = 1'b0; do_send = 1'b0; do_recv = 1'b0;
    case (r_q.command)
      CmdCreate: begin
        if (!name_ok) st = StInval;
        else if (r_q.peer_id != PeerAny && r_q.peer_id >= 5'(Principals))
          st = StInval;
        else if (r_q.queue_depth == 8'd0 || r_q.queue_depth > 8'(RingDepth)) st = StInval;
        else if (r_q.message_limit == 8'd0 || r_q.message_limit > 8'(MsgBytes))
          st = StInval;
        else if (found) st = StExists;
        else if (r_q.rights[1:0] == 2'b00) st = StInval;
        else if (r_q.peer_rights == 2'b00 && r_q.peer_id != {1'b0, r_q.principal}
                 && r_q.peer_id != PeerAny) st = StInval;
        else if (!free_any) st = StNospc;
        else do_create = 1'b1;
      end
      CmdOpen: begin
        if (!name_ok || !found) st = StNoent;
        else if (!core_match) st = StUnsup;
        else if (r_q.rights[3:2] != 2'b00) st = StInval;
        else if ((rts & r_q.rights[1:0]) != r_q.rights[1:0]) st = StAccess;
      end
      CmdSend: begin
        if (r_q.length == 8'd0 || !chan_ok) st = StInval;
        else if (!used_q[sel]) st = StNoent;
        else if (!core_match) st = StUnsup;
        else if ((rts & RightSend) == 2'b00) st = StAccess;
        else if (r_q.length > {4'd0, limit_q[sel]}) st = StToolong;
        else if (count_q[sel] >= depth_q[sel]) st = StFull;
        else do_send = 1'b1;
      end
      CmdRecv: begin
        if (!chan_ok) st = StInval;
        else if (!used_q[sel]) st = StNoent;
        else if (!core_match) st = StUnsup;
        else if ((rts & RightRecv) == 2'b00) st = StAccess;
        else if (count_q[sel] == '0) st = StEmpty;
        else if (r_q.length < {4'd0, rd_len}) st = StToolong;
        else do_recv = 1'b1;
      end
      default: st = StInval;
    endcase
  end

  assign wr_en = cmd_i.exec && do_send;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) r_q <= req_i;
    if (cmd_i.exec) begin
      rsp_o.status <= st;
      if (do_create) rsp_o.channel_number <= 3'(free_idx);
      else if (r_q.command == CmdOpen && st == StOk) rsp_o.channel_number <= 3'(found_idx);
      else rsp_o.channel_number <= '0;
      if (do_recv) begin
        rsp_o.message_length <= rd_len;
        rsp_o.message_data   <= rd_data & byte_mask(rd_len);
      end else begin
        rsp_o.message_length <= '0;
        rsp_o.message_data   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        core_q[i] <= '0; owner_q[i] <= '0; peer_q[i] <= '0;
        orights_q[i] <= '0; prights_q[i] <= '0; depth_q[i] <= '0;
        limit_q[i] <= '0; head_q[i] <= '0; count_q[i] <= '0; name_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (do_create) begin
        used_q[free_idx]    <= 1'b1;
        core_q[free_idx]    <= CoreW'(r_q.core);
        owner_q[free_idx]   <= r_q.principal;
        peer_q[free_idx]    <= r_q.peer_id;
        orights_q[free_idx] <= r_q.rights[1:0];
        prights_q[free_idx] <= r_q.peer_rights;
        depth_q[free_idx]   <= CntW'(r_q.queue_depth);
        limit_q[free_idx]   <= r_q.message_limit[3:0];
        head_q[free_idx]    <= '0;
        count_q[free_idx]   <= '0;
        name_q[free_idx]    <= canon;
      end
      if (do_send) count_q[sel] <= count_q[sel] + CntW'(1);
      if (do_recv) begin
        count_q[sel] <= count_q[sel] - CntW'(1);
        if (CntW'(head_q[sel]) + CntW'(1) >= depth_q[sel]) head_q[sel] <= '0;
        else head_q[sel] <= head_q[sel] + SlotW'(1);
      end
    end
  end
endmodule

>>> hw/rtl/acl_message_fifo_channels.sv
// Top level: mailbox of named, access-checked message channels.
// Usage:
//   s_axis_* carries one request (create, open, send, receive) per beat.
//   m_axis_* returns exactly one response per request, in order.
//   cfg_* writes the root principal, which holds every right on all channels.
// Sequence:
//   Each request is captured on acceptance, then the ring memory is read at
//   the selected slot, then the channel table and ring are checked and updated,
//   and the response turns valid.
//   A new request is accepted only once the previous response has been taken;
//   the controller handles one request at a time around the ring memory port.
// Stall:
//   While a response waits for m_axis_tready, no new request is accepted.
// Reset:
//   All channels become unused and the root principal is 0. The message rings
//   need no clearing; a slot is read only after a send has written it.
module acl_message_fifo_channels import amfc_pkg::*; #(
  parameter int unsigned Channels   = DefChannels,
  parameter int unsigned RingDepth  = DefRingDepth,
  parameter int unsigned MsgBytes   = DefMsgBytes,
  parameter int unsigned NameChars  = DefNameChars,
  parameter int unsigned Principals = DefPrincipals,
  parameter int unsigned Cores      = DefCores
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command, core, principal, channel_name, peer_id, rights, peer_rights,
  // queue_depth, message_limit, channel, length, payload (from bit 0), zero pad
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, channel_number, message_length, message_data (from bit 0), zero pad
  output logic [79:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_data_i
);
  logic [3:0] root_q;
  ctl_cmd_t   cmd;
  req_t       req;
  rsp_t       rsp;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_valid_i) begin
      root_q <= cfg_data_i;
    end
  end

  assign req.command        = s_axis_tdata[1:0];
  assign req.core           = s_axis_tdata[3:2];
  assign req.principal      = s_axis_tdata[7:4];
  assign req.channel_name   = s_axis_tdata[71:8];
  assign req.peer_id        = s_axis_tdata[76:72];
  assign req.rights         = s_axis_tdata[80:77];
  assign req.peer_rights    = s_axis_tdata[82:81];
  assign req.queue_depth    = s_axis_tdata[90:83];
  assign req.message_limit  = s_axis_tdata[98:91];
  assign req.channel        = s_axis_tdata[102:99];
  assign req.length         = s_axis_tdata[110:103];
  assign req.payload        = s_axis_tdata[174:111];

  assign m_axis_tdata = {5'd0, rsp.message_data, rsp.message_length,
                         rsp.channel_number, rsp.status};

  amfc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd)
  );

  amfc_dpath #(
    .Channels(Channels), .RingDepth(RingDepth), .MsgBytes(MsgBytes),
    .NameChars(NameChars), .Principals(Principals), .Cores(Cores)
  ) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(req), .root_i(root_q), .rsp_o(rsp)
  );
endmodule
